// ===== design/tracker_module_header_sizer_core_macros.svh =====
// Assertion helpers shared by the header sizer RTL.
// Each expects i_clk and i_rst_n in scope.
`ifndef TRACKER_MODULE_HEADER_SIZER_CORE_MACROS_SVH
`define TRACKER_MODULE_HEADER_SIZER_CORE_MACROS_SVH

// Same-cycle implication.
`define TMHS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TMHS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tmhs_pkg.sv =====
package tmhs_pkg;

    localparam int SAMPLE_SLOTS  = 31;
    localparam int SAMPLE_STRIDE = 'h1e;
    localparam int SAMPLE_BASE   = 'h2a;
    localparam int SAMPLE_END    = SAMPLE_BASE + SAMPLE_STRIDE * SAMPLE_SLOTS;
    localparam int SONG_LEN_POS  = 'h3b6;
    localparam int TABLE_BASE    = 'h3b8;
    localparam int TABLE_END     = 'h438;
    localparam int HEADER_BYTES  = 1084;
    localparam int ROW_BYTES     = 64 * 4;

    localparam int POS_W   = 11;
    localparam int SUM_W   = 23;
    localparam int PHASE_W = $clog2(SAMPLE_STRIDE);
    localparam int IDX_W   = $clog2(TABLE_END - TABLE_BASE);

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [SUM_W-1:0] LEN_MAX = '1;
    localparam logic [23:0]      MAX_LENGTH_RESET = 24'hFFFFFF;

    // Configuration register map, word index.
    localparam int REG_MAX_LENGTH = 0;
    localparam int PADDR_W        = 3;

    localparam int TAG_COUNT = 6;
    localparam logic [31:0] TAG_WORD [TAG_COUNT] = '{
        32'h4D2E4B2E,  // M.K.
        32'h3443484E,  // 4CHN
        32'h3643484E,  // 6CHN
        32'h3843484E,  // 8CHN
        32'h464C5434,  // FLT4
        32'h464C5438   // FLT8
    };
    localparam logic [3:0] TAG_CHANS [TAG_COUNT] = '{4'd4, 4'd4, 4'd6, 4'd8, 4'd4, 4'd8};

    typedef enum logic [1:0] {
        ST_NO_MATCH = 2'd0,
        ST_REJECTED = 2'd1,
        ST_ACCEPTED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        FMT_MK   = 3'd0,
        FMT_4CHN = 3'd1,
        FMT_6CHN = 3'd2,
        FMT_8CHN = 3'd3,
        FMT_FLT4 = 3'd4,
        FMT_FLT8 = 3'd5
    } t_format;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        t_format             format_type;
        logic [3:0]          channel_count;
        logic [SUM_W-1:0]    module_length;
    } t_out_item;

    // Header summary after the current byte is folded in.
    typedef struct packed {
        logic [SUM_W-1:0] sample_sum;
        logic [7:0]       max_pattern;
        logic [31:0]      signature;
    } t_scan_state;

endpackage

// ===== design/tmhs_scan.sv =====
module tmhs_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output tmhs_pkg::t_scan_state o_upd
);
    import tmhs_pkg::*;

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLE_STRIDE - 1);

    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [SUM_W-1:0]   r_sum,    n_sum;
    logic [7:0]         r_hi,     n_hi;
    logic [7:0]         r_song,   n_song;
    logic [7:0]         r_maxpat, n_maxpat;
    logic [31:0]        r_sig,    n_sig;

    logic             in_samp;
    logic             in_tab;
    logic [IDX_W-1:0] tab_idx;

    always_comb begin
        in_samp = (r_pos >= POS_W'(SAMPLE_BASE)) && (r_pos < POS_W'(SAMPLE_END));
        in_tab  = (r_pos >= POS_W'(TABLE_BASE)) && (r_pos < POS_W'(TABLE_END));
        tab_idx = IDX_W'(r_pos - POS_W'(TABLE_BASE));

        n_phase  = r_phase;
        n_hi     = r_hi;
        n_sum    = r_sum;
        n_song   = r_song;
        n_maxpat = r_maxpat;

        // Phase tracks the byte offset within the current sample slot.
        if (in_samp) begin
            n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + 1'b1;
            if (r_phase == PHASE_W'(0)) begin
                n_hi = i_byte;
            end else if (r_phase == PHASE_W'(1)) begin
                n_sum = r_sum + SUM_W'({r_hi, i_byte, 1'b0});
            end
        end
        if (r_pos == POS_W'(SONG_LEN_POS)) begin
            n_song = i_byte;
        end
        if (in_tab && ({1'b0, tab_idx} <= r_song) && (i_byte > r_maxpat)) begin
            n_maxpat = i_byte;
        end
        n_sig = {r_sig[23:0], i_byte};
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    end

    assign o_upd.sample_sum  = n_sum;
    assign o_upd.max_pattern = n_maxpat;
    assign o_upd.signature   = n_sig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_pos    <= '0;
            r_phase  <= '0;
            r_sum    <= '0;
            r_hi     <= '0;
            r_song   <= '0;
            r_maxpat <= '0;
            r_sig    <= '0;
        end else if (i_adv) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_hi     <= n_hi;
            r_song   <= n_song;
            r_maxpat <= n_maxpat;
            r_sig    <= n_sig;
        end
    end

endmodule

// ===== design/tmhs_size.sv =====
module tmhs_size (
    input  tmhs_pkg::t_scan_state i_scan,
    input  logic [23:0]           i_max_length,
    output tmhs_pkg::t_out_item   o_result
);
    import tmhs_pkg::*;

    logic        found;
    t_format     fmt;
    logic [3:0]  chans;
    logic [8:0]  rows;
    logic [12:0] row_chans;
    logic [20:0] pat_bytes;
    logic [23:0] total;
    logic [SUM_W-1:0] len_sat;

    always_comb begin
        found = 1'b0;
        fmt   = FMT_MK;
        chans = '0;
        for (int t = 0; t < TAG_COUNT; t++) begin
            if (!found && (i_scan.signature == TAG_WORD[t])) begin
                found = 1'b1;
                fmt   = t_format'(3'(t));
                chans = TAG_CHANS[t];
            end
        end

        rows      = {1'b0, i_scan.max_pattern} + 9'd1;
        row_chans = 13'(rows * chans);
        pat_bytes = 21'(row_chans) * 21'(ROW_BYTES);
        total     = {1'b0, i_scan.sample_sum} + 24'(pat_bytes) + 24'(HEADER_BYTES);
        len_sat   = (total > {1'b0, LEN_MAX}) ? LEN_MAX : total[SUM_W-1:0];

        if (!found) begin
            o_result = '0;
        end else begin
            o_result.status        = ({1'b0, len_sat} > i_max_length) ? ST_REJECTED
                                                                      : ST_ACCEPTED;
            o_result.format_type   = fmt;
            o_result.channel_count = chans;
            o_result.module_length = len_sat;
        end
    end

endmodule

// ===== design/tracker_module_header_sizer_core.sv =====
// Tracker module header sizer, streaming one header byte per transaction.
// Throughput: one input transaction per cycle, sustained, while results drain.
// The last-byte transaction passes the input register, then loads the result register.
// Only a last byte waits on the result register; the bytes behind it wait on the input register.
// Reset (i_rst_n low, synchronous): clear the scan state and both valid flags,
// and restore max_length to 16777215.
`include "tracker_module_header_sizer_core_macros.svh"

module tracker_module_header_sizer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Header byte stream
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tmhs_pkg::t_in_item          i_in_data,
    // Size result stream
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tmhs_pkg::t_out_item         o_out_data,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmhs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tmhs_pkg::*;

    // Input register: holds one accepted byte until the scan stage folds it in.
    logic      r_in_valid;
    t_in_item  r_in;

    // Result register: holds the finished transaction until the sink takes it.
    logic      r_out_valid;
    t_out_item r_out;

    logic [23:0] r_max_length;

    logic        out_free;
    logic        stage_go;
    logic        reg_sel;
    t_scan_state scan_upd;
    t_out_item   size_result;

    // Let ordinary bytes through unconditionally; a last byte needs the result
    // register free (or being emptied this cycle).
    assign out_free   = !r_out_valid || i_out_ready;
    assign stage_go   = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_ready = !r_in_valid || stage_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Fold the held byte into the running header summary.
    tmhs_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (stage_go),
        .i_byte  (r_in.header_byte),
        .i_last  (r_in.last_byte),
        .o_upd   (scan_upd)
    );

    // Match the signature and size the module from the updated summary.
    tmhs_size u_size (
        .i_scan       (scan_upd),
        .i_max_length (r_max_length),
        .o_result     (size_result)
    );

    // Load a result on the last byte; drop valid once the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go && r_in.last_byte) begin
            r_out <= size_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration: single word register, decoded on the word address.
    assign reg_sel = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_MAX_LENGTH));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {8'h00, r_max_length} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_max_length <= pwdata[23:0];
        end
    end

    `TMHS_ASSERT_NXT(a_last_gives_result, stage_go && r_in.last_byte, r_out_valid,
        "last byte did not load a result")
    `TMHS_ASSERT_IMP(a_no_match_zero,
        r_out_valid && (r_out.status == ST_NO_MATCH),
        (r_out.channel_count == 4'd0) && (r_out.module_length == '0),
        "unmatched result carries nonzero fields")
    `TMHS_ASSERT_IMP(a_accept_in_limit,
        r_out_valid && (r_out.status == ST_ACCEPTED),
        {1'b0, r_out.module_length} <= r_max_length,
        "accepted module exceeds size limit")
    `TMHS_ASSERT_IMP(a_match_chans,
        r_out_valid && (r_out.status != ST_NO_MATCH),
        (r_out.channel_count == 4'd4) || (r_out.channel_count == 4'd6)
            || (r_out.channel_count == 4'd8),
        "matched result has bad channel count")

endmodule

// ===== tb/tracker_module_header_sizer_core_test.sv =====
`timescale 1ns / 100ps

module tracker_module_header_sizer_core_test;
    import tmhs_pkg::*;

    // Header layout as the scanner sees it
    localparam int WORD_BASE    = 42;
    localparam int WORD_STRIDE  = 30;
    localparam int WORD_SLOTS   = 31;
    localparam int SONG_LEN_AT  = 950;
    localparam int ORDER_BASE   = 952;
    localparam int ORDER_END    = 1080;
    localparam int HEADER_LEN   = 1084;
    localparam int ROW_SET      = 64 * 4;
    localparam int LENGTH_CAP   = 8388607;

    // Cut header that runs past every sample length word and the song length
    // into the first order entries
    localparam int SONG_WINDOW  = 970;

    // Bench timing
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Scanner state mirrored by the predictor
    logic [10:0]           scan_pos = '0;
    logic [22:0]           scan_samples = '0;
    logic [7:0]            scan_high = '0;
    logic [7:0]            scan_song = '0;
    logic [7:0]            scan_top_pattern = '0;
    logic [31:0]           scan_signature = '0;
    logic [23:0]           size_limit = 24'hFFFFFF;

    t_out_item             expected_sizes[$];

    int                    mismatch_count = 0;
    int                    bytes_sent = 0;
    int                    windows_sent = 0;
    int                    accepted_seen = 0;
    int                    rejected_seen = 0;
    int                    unmatched_seen = 0;
    int                    quiet_cycles = 0;
    bit                    idle_on = 1'b1;
    bit                    hold_request = 1'b0;

    tracker_module_header_sizer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Tag words and their channel counts, big-endian as they sit in the
    // last four header bytes.
    // ------------------------------------------------------------------
    function automatic logic [31:0] tag_word(input t_format fmt);
        case (fmt)
            FMT_MK:   return "M.K.";
            FMT_4CHN: return "4CHN";
            FMT_6CHN: return "6CHN";
            FMT_8CHN: return "8CHN";
            FMT_FLT4: return "FLT4";
            default:  return "FLT8";
        endcase
    endfunction

    function automatic logic [3:0] tag_channels(input t_format fmt);
        case (fmt)
            FMT_6CHN:           return 4'd6;
            FMT_8CHN, FMT_FLT8: return 4'd8;
            default:            return 4'd4;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Fold one header byte into the mirrored scanner state. On the last
    // byte, size the module and clear the state for the next header.
    // ------------------------------------------------------------------
    function automatic void fold_header_byte(input logic [7:0] b, input logic last,
                                             output bit emit, output t_out_item res);
        int       pos;
        int       total;
        bit       hit;
        t_format  fmt;
        logic [3:0] chans;

        pos   = scan_pos;
        emit  = 1'b0;
        res   = '0;
        hit   = 1'b0;
        fmt   = FMT_MK;
        chans = '0;

        // Sample lengths: latch the high byte, add the word times two on the low byte
        if (pos >= WORD_BASE && pos < WORD_BASE + WORD_STRIDE * WORD_SLOTS) begin
            if ((pos - WORD_BASE) % WORD_STRIDE == 0) begin
                scan_high = b;
            end else if ((pos - WORD_BASE) % WORD_STRIDE == 1) begin
                scan_samples = 23'(int'(scan_samples) + int'({scan_high, b}) * 2);
            end
        end
        if (pos == SONG_LEN_AT) begin
            scan_song = b;
        end
        // Order table: only entries up to the song length count
        if (pos >= ORDER_BASE && pos < ORDER_END) begin
            if (pos - ORDER_BASE <= int'(scan_song) && b > scan_top_pattern) begin
                scan_top_pattern = b;
            end
        end
        scan_signature = {scan_signature[23:0], b};
        if (scan_pos != 11'h7FF) begin
            scan_pos = scan_pos + 11'd1;
        end

        if (last) begin
            emit = 1'b1;
            for (int f = FMT_MK; f <= FMT_FLT8; f++) begin
                if (!hit && scan_signature == tag_word(t_format'(f))) begin
                    hit   = 1'b1;
                    fmt   = t_format'(f);
                    chans = tag_channels(t_format'(f));
                end
            end
            if (hit) begin
                total = int'(scan_samples) + (int'(scan_top_pattern) + 1) * ROW_SET * chans
                        + HEADER_LEN;
                if (total > LENGTH_CAP) begin
                    total = LENGTH_CAP;
                end
                res.status        = (total > int'(size_limit)) ? ST_REJECTED : ST_ACCEPTED;
                res.format_type   = fmt;
                res.channel_count = chans;
                res.module_length = 23'(total);
            end else begin
                res.status = ST_NO_MATCH;
            end
            scan_pos         = '0;
            scan_samples     = '0;
            scan_high        = '0;
            scan_song        = '0;
            scan_top_pattern = '0;
            scan_signature   = '0;
        end
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t: %s got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Predict on every accepted header byte transaction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : predict_sizes
        bit        emit;
        t_out_item res;
        if (i_rst_n && in_valid && in_ready) begin
            fold_header_byte(in_item.header_byte, in_item.last_byte, emit, res);
            bytes_sent++;
            if (emit) begin
                expected_sizes.push_back(res);
            end
        end
    end

    // ------------------------------------------------------------------
    // Compare each accepted result transaction with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_sizes
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_sizes.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(out_item), '0);
            end else begin
                want = expected_sizes.pop_front();
                case (want.status)
                    ST_ACCEPTED: accepted_seen++;
                    ST_REJECTED: rejected_seen++;
                    default:     unmatched_seen++;
                endcase
                if (out_item.status !== want.status)
                    report_mismatch("status", 32'(out_item.status), 32'(want.status));
                if (out_item.format_type !== want.format_type)
                    report_mismatch("format_type", 32'(out_item.format_type),
                                    32'(want.format_type));
                if (out_item.channel_count !== want.channel_count)
                    report_mismatch("channel_count", 32'(out_item.channel_count),
                                    32'(want.channel_count));
                if (out_item.module_length !== want.module_length)
                    report_mismatch("module_length", 32'(out_item.module_length),
                                    32'(want.module_length));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: take the long hold when asked, else stall in random
    // bursts while idling is on.
    // ------------------------------------------------------------------
    initial begin : drain_results
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                for (held = 1; held < LONG_HOLD; held++) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Abort if no transaction moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tracker_module_header_sizer_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one header byte; hold valid and payload until accepted
    task automatic send_header_byte(input logic [7:0] b, input logic last);
        t_in_item item;
        item.header_byte = b;
        item.last_byte   = last;
        if (idle_on && $urandom_range(0, 11) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Send one window of len bytes with random content; place the song
    // length and order table where they belong, and end on a tag if asked.
    task automatic send_module_header(input int len, input bit tagged_end,
                                      input t_format fmt, input logic [7:0] song,
                                      input bit wide_orders);
        logic [31:0] tag;
        logic [7:0]  b;
        tag = tag_word(fmt);
        for (int pos = 0; pos < len; pos++) begin
            b = 8'($urandom_range(0, 255));
            if (tagged_end && pos >= len - 4) begin
                b = tag[8 * (len - 1 - pos) +: 8];
            end else if (pos == SONG_LEN_AT) begin
                b = song;
            end else if (pos >= ORDER_BASE && pos < ORDER_END && !wide_orders) begin
                b = 8'($urandom_range(0, 63));
            end
            send_header_byte(b, pos == len - 1);
        end
        windows_sent++;
    endtask

    // Drop valid, wait for every pending result, then let the pipe settle
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_sizes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_max_length(output logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(4 * REG_MAX_LENGTH);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        value   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the size limit while idle and read it back
    task automatic set_max_length(input logic [23:0] limit);
        logic [31:0] readback;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_MAX_LENGTH);
        pwdata  <= {8'h00, limit};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_limit = limit;
        read_max_length(readback);
        if (readback[23:0] !== limit)
            report_mismatch("max_length readback", 32'(readback[23:0]), 32'(limit));
    endtask

    // Pick a short window shape: mostly tagged, some cut just past the
    // first sample length word, some noise without a tag.
    task automatic send_random_window();
        int         kind;
        t_format    fmt;
        kind = $urandom_range(0, 9);
        fmt  = t_format'($urandom_range(FMT_MK, FMT_FLT8));
        if (kind <= 6)
            send_module_header($urandom_range(4, 12), 1'b1, fmt, 8'd0, 1'b0);
        else if (kind == 7)
            send_module_header($urandom_range(48, 52), 1'b1, fmt, 8'd0, 1'b0);
        else
            send_module_header($urandom_range(1, 12), 1'b0, fmt, 8'd0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The size limit comes out of reset at its maximum
    task automatic test_reset_value();
        logic [31:0] value;
        read_max_length(value);
        if (value[23:0] !== 24'hFFFFFF)
            report_mismatch("max_length after reset", 32'(value[23:0]), 32'hFFFFFF);
    endtask

    // Each tag as a four-byte window, then a one-byte window of all ones
    // that leaves zeros in the rest of the signature and matches nothing
    task automatic test_signature_tags();
        for (int f = FMT_MK; f <= FMT_FLT8; f++) begin
            send_module_header(4, 1'b1, t_format'(f), 8'd0, 1'b0);
        end
        send_header_byte(8'hFF, 1'b1);
        windows_sent++;
        wait_for_results();
    endtask

    // Cut header through every sample length word and the song length into the
    // order table; entries past the song length may carry large patterns that
    // must not count
    task automatic test_song_limit();
        send_module_header(SONG_WINDOW, 1'b1, FMT_6CHN, 8'd6, 1'b1);
        wait_for_results();
    endtask

    // Random windows across several size limits, the extremes among them
    // and the exact size of a bare four-channel header
    task automatic test_random_headers();
        logic [23:0] limit;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       limit = 24'd0;
                1:       limit = 24'(HEADER_LEN + ROW_SET * 4);
                2:       limit = 24'(HEADER_LEN + ROW_SET * 4 - 1);
                3:       limit = 24'd2_000_000;
                4:       limit = 24'($urandom_range(0, 24'hFFFFFF));
                default: limit = 24'hFFFFFF;
            endcase
            set_max_length(limit);
            repeat (2) send_random_window();
            wait_for_results();
        end
    endtask

    // Hold the result side off while short windows keep coming, so the
    // result stage fills and the last-byte transaction stalls
    task automatic test_backpressure();
        @(negedge i_clk);
        hold_request = 1'b1;
        @(posedge i_clk);
        repeat (5) begin
            send_module_header(4, 1'b1, t_format'($urandom_range(FMT_MK, FMT_FLT8)),
                               8'd0, 1'b0);
        end
        wait_for_results();
    endtask

    // Back-to-back windows with no idling on either side, under a limit
    // between 2000 and 4000 that may split the channel counts
    task automatic test_final_stream();
        idle_on = 1'b0;
        set_max_length(24'($urandom_range(2_000, 4_000)));
        repeat (6) send_module_header($urandom_range(4, 8), 1'b1,
                                      t_format'($urandom_range(FMT_MK, FMT_FLT8)),
                                      8'd0, 1'b0);
        wait_for_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_value();
        test_signature_tags();
        test_song_limit();
        test_random_headers();
        test_backpressure();
        test_final_stream();

        $display("Covered %0d header bytes in %0d windows: all six tags, short, cut",
                 bytes_sent, windows_sent);
        $display("and untagged windows; results %0d accepted, %0d rejected, %0d unmatched",
                 accepted_seen, rejected_seen, unmatched_seen);
        if (mismatch_count == 0) begin
            $display("tracker_module_header_sizer_core: match");
        end else begin
            $display("tracker_module_header_sizer_core: mismatch");
        end
        $finish;
    end

endmodule
